// ----- hdl/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg: shared types, constants and helpers of the attitude filter
// Fixed-point formats, state machine encoding, register indexes and the
// saturation and format conversion functions used by the filter datapath.
// ----------------------------------------------------------------------------
package cfa_pkg;

  // Fraction bits of the internal angle and rate format
  localparam int FRAC_BITS = 16;
  localparam int IO_FRAC   = 16;
  localparam int UPS       = (FRAC_BITS > IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
  localparam int DNS       = (FRAC_BITS < IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;

  // Field widths
  localparam int ANG_W  = 25;
  localparam int RATE_W = 28;
  localparam int Q24_W  = 24;
  localparam int ST_W   = 48;
  localparam int SUM_W  = ST_W + 2;

  // Serial multiplier: one multiplier bit per step
  localparam int MUL_STEPS = Q24_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);

  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic        [Q24_W-1:0]  q24_t;
  typedef logic signed [ST_W-1:0]   st_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [0:0]        cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t CFG_BANDWIDTH_K = 1'd0;
  localparam cfg_idx_t CFG_TILT_LIMIT  = 1'd1;

  localparam q24_t BANDWIDTH_K_RST = 24'd117440;
  localparam q24_t TILT_LIMIT_RST  = 24'd1966080;

  // Item function codes
  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam st_t ST_MAX    = {1'b0, {(ST_W-1){1'b1}}};
  localparam st_t ST_MIN    = {1'b1, {(ST_W-1){1'b0}}};
  localparam st_t ANGLE_MAX = st_t'(180) <<< FRAC_BITS;
  localparam st_t ANGLE_MIN = -ANGLE_MAX;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_KK,
    S_ERR,
    S_M1,
    S_M2,
    S_MK,
    S_MD,
    S_OUT
  } cfa_state_t;

  // Q16.16 to internal format
  function automatic st_t to_int(input st_t v);
    st_t x;
    x = v <<< UPS;
    return x >>> DNS;
  endfunction

  // Internal format to Q16.16
  function automatic st_t to_io(input st_t v);
    st_t x;
    x = v <<< DNS;
    return x >>> UPS;
  endfunction

  // Saturate to the 48-bit signed range
  function automatic st_t sat_st(input sum_t v);
    if (v > sum_t'(ST_MAX)) return ST_MAX;
    if (v < sum_t'(ST_MIN)) return ST_MIN;
    return st_t'(v);
  endfunction

  // Saturate to +-180 degrees
  function automatic st_t clamp_ang(input sum_t v);
    if (v > sum_t'(ANGLE_MAX)) return ANGLE_MAX;
    if (v < sum_t'(ANGLE_MIN)) return ANGLE_MIN;
    return st_t'(v);
  endfunction

endpackage

// ----- hdl/cfa_if.sv -----
// ----------------------------------------------------------------------------
// cfa_if: valid/ready channels of the attitude filter
// Sensor item channel and filtered attitude result channel.
// ----------------------------------------------------------------------------
interface cfa_in_if;
  import cfa_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  ang_t  accel_roll;
  ang_t  accel_pitch;
  rate_t gyro_roll_rate;
  rate_t gyro_pitch_rate;
  q24_t  dt;
  logic  freefall;

  modport source (
    output valid, func, accel_roll, accel_pitch, gyro_roll_rate, gyro_pitch_rate,
           dt, freefall,
    input  ready
  );
  modport sink (
    input  valid, func, accel_roll, accel_pitch, gyro_roll_rate, gyro_pitch_rate,
           dt, freefall,
    output ready
  );
endinterface

interface cfa_out_if;
  import cfa_pkg::*;

  logic valid;
  logic ready;
  ang_t roll_out;
  ang_t pitch_out;

  modport source (output valid, roll_out, pitch_out, input ready);
  modport sink   (input valid, roll_out, pitch_out, output ready);
endinterface

// ----- hdl/cfa_sermul.sv -----
// ----------------------------------------------------------------------------
// cfa_sermul: bit-serial signed by Q0.24 multiplier
// Computes floor(a * m / 2^24) for signed 48-bit a and unsigned 24-bit m,
// one multiplier bit per cycle, LSB first, with the accumulator shifting right.
// ----------------------------------------------------------------------------
module cfa_sermul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cfa_pkg::st_t  a,
  input  cfa_pkg::q24_t m,
  output logic          done,
  output cfa_pkg::st_t  p
);
  import cfa_pkg::*;

  st_t                    a_r, a_nxt;
  q24_t                   m_r, m_nxt;
  st_t                    acc_r, acc_nxt;
  logic [MCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic signed [ST_W:0]   sum;

  // One step: add the multiplicand if the current bit is set, then floor-halve
  assign sum = {acc_r[ST_W-1], acc_r} + (m_r[0] ? {a_r[ST_W-1], a_r} : '0);

  always_comb begin
    a_nxt    = a_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      m_nxt    = m;
      acc_nxt  = '0;
      cnt_nxt  = MCNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = sum[ST_W:1];
      m_nxt    = m_r >> 1;
      cnt_nxt  = cnt_r - MCNT_W'(1);
      busy_nxt = (cnt_r != MCNT_W'(1));
      done_nxt = (cnt_r == MCNT_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and accumulator shift registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- hdl/complementary_attitude_filter.sv -----
// ----------------------------------------------------------------------------
// complementary_attitude_filter: two-axis second-order complementary filter
// Fuses accelerometer angles and gyro rates into roll and pitch estimates,
// with a bias integrator per axis, in fixed point with a bit-serial multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake         Contents
//  in_ch     in   valid/ready       func, accel angles, gyro rates, dt, freefall
//  out_ch    out  valid/ready       roll_out, pitch_out
//  cfg_*     in   cfg_we            bandwidth_k (0), tilt_limit (1)
//
// An init transaction goes from idle straight to the output state. An update
// transaction runs nine multiplies on the shared bit-serial unit (K*K once,
// then four per axis), each a start, 24 steps and a capture, plus an error
// step per axis and the output step.
// One transaction is in work at a time; a new one is accepted while the last
// result still waits in the output register, and the input stalls once its
// result is ready and the output register is still full. Synchronous reset
// clears the estimates and integrators and loads the register defaults.
// ----------------------------------------------------------------------------
module complementary_attitude_filter (
  input  logic            clk,
  input  logic            rst_n,
  cfa_in_if.sink          in_ch,
  cfa_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cfa_pkg::cfg_idx_t cfg_index,
  input  cfa_pkg::q24_t   cfg_data
);
  import cfa_pkg::*;

  cfa_state_t state_r, state_nxt;

  // Configuration
  q24_t bw_k_r, bw_k_nxt;
  q24_t tilt_r, tilt_nxt;

  // Filter state, per axis (0 roll, 1 pitch)
  st_t est_r   [0:1];
  st_t est_nxt [0:1];
  st_t integ_r   [0:1];
  st_t integ_nxt [0:1];

  // Latched item
  st_t  accel_r   [0:1];
  st_t  accel_nxt [0:1];
  st_t  rate_r    [0:1];
  st_t  rate_nxt  [0:1];
  q24_t dt_r, dt_nxt;
  logic ff_r, ff_nxt;

  // Working registers
  logic axis_r, axis_nxt;
  q24_t kk_r, kk_nxt;
  st_t  e_r, e_nxt;
  st_t  tmp_r, tmp_nxt;
  logic started_r, started_nxt;

  // Output register
  ang_t roll_out_r, roll_out_nxt;
  ang_t pitch_out_r, pitch_out_nxt;
  logic out_valid_r, out_valid_nxt;

  // Control
  logic in_fire;
  logic in_mul;
  logic mul_start;
  logic mul_done;
  st_t  mul_a;
  q24_t mul_m;
  st_t  mul_p;
  logic out_load;

  // Datapath helpers
  st_t  ar_int, ap_int, gr_int, gp_int;
  st_t  est_cur, integ_cur, accel_cur, rate_cur;
  st_t  lim;
  logic ignore;
  st_t  io_roll, io_pitch;

  assign in_fire = in_ch.valid && in_ch.ready;

  assign ar_int = to_int(st_t'(in_ch.accel_roll));
  assign ap_int = to_int(st_t'(in_ch.accel_pitch));
  assign gr_int = to_int(st_t'(in_ch.gyro_roll_rate));
  assign gp_int = to_int(st_t'(in_ch.gyro_pitch_rate));

  assign est_cur   = est_r[axis_r];
  assign integ_cur = integ_r[axis_r];
  assign accel_cur = accel_r[axis_r];
  assign rate_cur  = rate_r[axis_r];

  // Tilt test: strict compare against the converted limit
  assign lim    = to_int(st_t'({{(ST_W-Q24_W){1'b0}}, tilt_r}));
  assign ignore = ff_r || (est_cur > lim) || (est_cur < -lim);

  assign io_roll  = to_io(est_r[0]);
  assign io_pitch = to_io(est_r[1]);

  cfa_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .m     (mul_m),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = (in_ch.func == FUNC_UPDATE) ? S_KK : S_OUT;
      end
      S_KK:  if (mul_done) state_nxt = S_ERR;
      S_ERR: state_nxt = S_M1;
      S_M1:  if (mul_done) state_nxt = S_M2;
      S_M2:  if (mul_done) state_nxt = S_MK;
      S_MK:  if (mul_done) state_nxt = S_MD;
      S_MD:  if (mul_done) state_nxt = axis_r ? S_OUT : S_ERR;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    in_ch.ready = 1'b0;
    in_mul      = 1'b0;
    out_load    = 1'b0;
    mul_a       = tmp_r;
    mul_m       = dt_r;
    unique case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_KK: begin
        in_mul = 1'b1;
        mul_a  = st_t'({{(ST_W-Q24_W){1'b0}}, bw_k_r});
        mul_m  = bw_k_r;
      end
      S_ERR: ;
      S_M1: begin
        in_mul = 1'b1;
        mul_a  = e_r;
        mul_m  = kk_r;
      end
      S_M2: begin
        in_mul = 1'b1;
        mul_a  = tmp_r;
        mul_m  = dt_r;
      end
      S_MK: begin
        in_mul = 1'b1;
        mul_a  = e_r <<< 1;
        mul_m  = bw_k_r;
      end
      S_MD: begin
        in_mul = 1'b1;
        mul_a  = tmp_r;
        mul_m  = dt_r;
      end
      S_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
    mul_start = in_mul && !started_r;
  end

  // Datapath next values
  always_comb begin
    bw_k_nxt      = bw_k_r;
    tilt_nxt      = tilt_r;
    est_nxt       = est_r;
    integ_nxt     = integ_r;
    accel_nxt     = accel_r;
    rate_nxt      = rate_r;
    dt_nxt        = dt_r;
    ff_nxt        = ff_r;
    axis_nxt      = axis_r;
    kk_nxt        = kk_r;
    e_nxt         = e_r;
    tmp_nxt       = tmp_r;
    roll_out_nxt  = roll_out_r;
    pitch_out_nxt = pitch_out_r;
    started_nxt   = in_mul && !mul_done;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    // Register writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BANDWIDTH_K: bw_k_nxt = cfg_data;
        CFG_TILT_LIMIT:  tilt_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          accel_nxt[0] = ar_int;
          accel_nxt[1] = ap_int;
          rate_nxt[0]  = gr_int;
          rate_nxt[1]  = gp_int;
          dt_nxt       = in_ch.dt;
          ff_nxt       = in_ch.freefall;
          axis_nxt     = 1'b0;
          // Init loads the estimates and the negated rates directly
          if (in_ch.func == FUNC_INIT) begin
            est_nxt[0]   = clamp_ang(sum_t'(ar_int));
            est_nxt[1]   = clamp_ang(sum_t'(ap_int));
            integ_nxt[0] = -gr_int;
            integ_nxt[1] = -gp_int;
          end
        end
      end
      S_KK: if (mul_done) kk_nxt = mul_p[Q24_W-1:0];
      S_ERR: e_nxt = ignore ? '0 : accel_cur - est_cur;
      S_M1: if (mul_done) tmp_nxt = mul_p;
      S_M2: begin
        if (mul_done) integ_nxt[axis_r] = sat_st(sum_t'(integ_cur) + sum_t'(mul_p));
      end
      S_MK: begin
        // Derivative term: new integrator + 2*K*e + rate
        if (mul_done) tmp_nxt = sat_st(sum_t'(integ_cur) + sum_t'(mul_p) + sum_t'(rate_cur));
      end
      S_MD: begin
        if (mul_done) begin
          est_nxt[axis_r] = clamp_ang(sum_t'(est_cur) + sum_t'(mul_p));
          axis_nxt        = 1'b1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          roll_out_nxt  = io_roll[ANG_W-1:0];
          pitch_out_nxt = io_pitch[ANG_W-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      bw_k_r      <= BANDWIDTH_K_RST;
      tilt_r      <= TILT_LIMIT_RST;
      est_r[0]    <= '0;
      est_r[1]    <= '0;
      integ_r[0]  <= '0;
      integ_r[1]  <= '0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      bw_k_r      <= bw_k_nxt;
      tilt_r      <= tilt_nxt;
      est_r       <= est_nxt;
      integ_r     <= integ_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    accel_r     <= accel_nxt;
    rate_r      <= rate_nxt;
    dt_r        <= dt_nxt;
    ff_r        <= ff_nxt;
    kk_r        <= kk_nxt;
    e_r         <= e_nxt;
    tmp_r       <= tmp_nxt;
    roll_out_r  <= roll_out_nxt;
    pitch_out_r <= pitch_out_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.roll_out  = roll_out_r;
  assign out_ch.pitch_out = pitch_out_r;

endmodule
